// ===== design/rmq_pkg.sv =====
package rmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 18;
  localparam int ARG_W     = IN_W + 1;
  localparam int RAD_W     = 36;
  localparam int ROOT_W    = 18;
  localparam int REM_W     = 20;
  localparam int NUM_W     = IN_W + 1;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int QB_W      = 17;
  localparam int SQRT_CELLS = ROOT_W;
  localparam int DIV_CELLS  = QB_W;
  localparam int LANES      = 3;
  localparam logic [QB_W-1:0] ONE = QB_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_PIV_X = 2'd1,
    BR_PIV_Y = 2'd2,
    BR_PIV_Z = 2'd3
  } branch_t;

  typedef struct packed {
    logic [RAD_W-1:0]              rad;
    logic [REM_W-1:0]              rem;
    logic [ROOT_W-1:0]             root;
    branch_t                       branch;
    logic [LANES-1:0][NUM_W-1:0]   num;
  } sqrt_t;

  typedef struct packed {
    logic [LANES-1:0][DEN_W-1:0]   rem;
    logic [LANES-1:0][QB_W-1:0]    low;
    logic [LANES-1:0][QB_W-1:0]    quo;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0]              ovf;
    logic [DEN_W-1:0]              den;
    logic [ROOT_W-1:0]             half;
    logic                          zero;
    branch_t                       branch;
  } div_t;

endpackage

// ===== design/rotation_matrix_to_quaternion.sv =====
// channel | signals                                   | direction
// input   | in_valid in_ready m00 .. m22              | matrix in
// output  | out_valid out_ready quat_x quat_y quat_z  | quaternion out
//         | quat_w branch_taken degenerate            |
// one item per cycle unless the output stalls; stages: input stage, 18 root cells,
// divider setup, 17 divider cells (three lanes each), output register
// reset clears only the valid bits along the chain
// the whole chain holds when the output register is full and not taken
module rotation_matrix_to_quaternion (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [17:0] m00,
  input  logic signed [17:0] m01,
  input  logic signed [17:0] m02,
  input  logic signed [17:0] m10,
  input  logic signed [17:0] m11,
  input  logic signed [17:0] m12,
  input  logic signed [17:0] m20,
  input  logic signed [17:0] m21,
  input  logic signed [17:0] m22,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] quat_x,
  output logic signed [17:0] quat_y,
  output logic signed [17:0] quat_z,
  output logic signed [17:0] quat_w,
  output logic [1:0]         branch_taken,
  output logic               degenerate
);

  localparam int SW = rmq_pkg::IN_W + 3;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // input stage
  logic signed [SW-1:0] d0, d1, d2, trace, dii, djj, dkk, arg_s;
  logic signed [rmq_pkg::NUM_W-1:0] n0, n1, n2;
  rmq_pkg::branch_t br;
  logic [rmq_pkg::ARG_W-1:0] arg;
  rmq_pkg::sqrt_t s_first;

  always_comb begin
    d0    = SW'(m00);
    d1    = SW'(m11);
    d2    = SW'(m22);
    trace = d0 + d1 + d2;
    if (trace > 0) begin
      br = rmq_pkg::BR_TRACE;
    end else if (d0 < d1) begin
      br = (d1 < d2) ? rmq_pkg::BR_PIV_Z : rmq_pkg::BR_PIV_Y;
    end else begin
      br = (d0 < d2) ? rmq_pkg::BR_PIV_Z : rmq_pkg::BR_PIV_X;
    end
    dii = d0;
    djj = d1;
    dkk = d2;
    n0  = rmq_pkg::NUM_W'(m21) - rmq_pkg::NUM_W'(m12);
    n1  = rmq_pkg::NUM_W'(m02) - rmq_pkg::NUM_W'(m20);
    n2  = rmq_pkg::NUM_W'(m10) - rmq_pkg::NUM_W'(m01);
    unique case (br)
      rmq_pkg::BR_TRACE: begin
      end
      rmq_pkg::BR_PIV_X: begin
        dii = d0; djj = d1; dkk = d2;
        n0  = rmq_pkg::NUM_W'(m21) - rmq_pkg::NUM_W'(m12);
        n1  = rmq_pkg::NUM_W'(m10) + rmq_pkg::NUM_W'(m01);
        n2  = rmq_pkg::NUM_W'(m20) + rmq_pkg::NUM_W'(m02);
      end
      rmq_pkg::BR_PIV_Y: begin
        dii = d1; djj = d2; dkk = d0;
        n0  = rmq_pkg::NUM_W'(m02) - rmq_pkg::NUM_W'(m20);
        n1  = rmq_pkg::NUM_W'(m21) + rmq_pkg::NUM_W'(m12);
        n2  = rmq_pkg::NUM_W'(m01) + rmq_pkg::NUM_W'(m10);
      end
      rmq_pkg::BR_PIV_Z: begin
        dii = d2; djj = d0; dkk = d1;
        n0  = rmq_pkg::NUM_W'(m10) - rmq_pkg::NUM_W'(m01);
        n1  = rmq_pkg::NUM_W'(m02) + rmq_pkg::NUM_W'(m20);
        n2  = rmq_pkg::NUM_W'(m12) + rmq_pkg::NUM_W'(m21);
      end
      default: begin
      end
    endcase
    if (br == rmq_pkg::BR_TRACE) begin
      arg_s = trace + SW'(rmq_pkg::ONE);
    end else begin
      arg_s = dii - djj - dkk + SW'(rmq_pkg::ONE);
    end
    arg = arg_s[SW-1] ? '0 : arg_s[rmq_pkg::ARG_W-1:0];
    s_first.rad    = rmq_pkg::RAD_W'({arg, rmq_pkg::FRAC_BITS'(0)});
    s_first.rem    = '0;
    s_first.root   = '0;
    s_first.branch = br;
    s_first.num    = {n2, n1, n0};
  end

  logic           sv [rmq_pkg::SQRT_CELLS+1];
  rmq_pkg::sqrt_t sd [rmq_pkg::SQRT_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= s_first;
    end
  end

  for (genvar c = 0; c < rmq_pkg::SQRT_CELLS; c++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (sv[c]),
      .data_in   (sd[c]),
      .valid_out (sv[c+1]),
      .data_out  (sd[c+1])
    );
  end

  // divider setup
  rmq_pkg::sqrt_t sl;
  rmq_pkg::div_t  d_first;
  logic [rmq_pkg::NUM_W-1:0] mag [rmq_pkg::LANES];
  logic [rmq_pkg::RAD_W-1:0] dvd [rmq_pkg::LANES];
  logic [rmq_pkg::ROOT_W:0]  r_inc;

  always_comb begin
    sl = sd[rmq_pkg::SQRT_CELLS];
    d_first.den    = {sl.root, 1'b0};
    r_inc          = {1'b0, sl.root} + 1'b1;
    d_first.half   = r_inc[rmq_pkg::ROOT_W:1];
    d_first.zero   = sl.root == '0;
    d_first.branch = sl.branch;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      d_first.neg[l] = sl.num[l][rmq_pkg::NUM_W-1];
      mag[l] = d_first.neg[l] ? rmq_pkg::NUM_W'(-sl.num[l]) : sl.num[l];
      dvd[l] = rmq_pkg::RAD_W'({mag[l], rmq_pkg::FRAC_BITS'(0)})
             + rmq_pkg::RAD_W'(sl.root);
      d_first.rem[l] = dvd[l][rmq_pkg::RAD_W-1 -: rmq_pkg::DEN_W];
      d_first.low[l] = dvd[l][rmq_pkg::QB_W-1:0];
      d_first.ovf[l] = dvd[l][rmq_pkg::RAD_W-1 -: rmq_pkg::DEN_W] >= d_first.den;
      d_first.quo[l] = '0;
    end
  end

  logic          dv [rmq_pkg::DIV_CELLS+1];
  rmq_pkg::div_t dd [rmq_pkg::DIV_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sv[rmq_pkg::SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= d_first;
    end
  end

  for (genvar c = 0; c < rmq_pkg::DIV_CELLS; c++) begin : g_div
    rmq_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (dv[c]),
      .data_in   (dd[c]),
      .valid_out (dv[c+1]),
      .data_out  (dd[c+1])
    );
  end

  // output stage
  rmq_pkg::div_t dl;
  logic [rmq_pkg::QB_W-1:0]   lmag [rmq_pkg::LANES];
  logic signed [17:0]         lval [rmq_pkg::LANES];
  logic signed [17:0]         hval;
  logic signed [17:0]         qx_next, qy_next, qz_next, qw_next;

  always_comb begin
    dl = dd[rmq_pkg::DIV_CELLS];
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      lmag[l] = (dl.ovf[l] || dl.quo[l] > rmq_pkg::ONE) ? rmq_pkg::ONE : dl.quo[l];
      lval[l] = dl.neg[l] ? -18'(lmag[l]) : 18'(lmag[l]);
    end
    hval = (dl.half > 18'(rmq_pkg::ONE)) ? 18'(rmq_pkg::ONE) : dl.half;
    unique case (dl.branch)
      rmq_pkg::BR_TRACE: begin
        qx_next = lval[0]; qy_next = lval[1]; qz_next = lval[2]; qw_next = hval;
      end
      rmq_pkg::BR_PIV_X: begin
        qx_next = hval; qw_next = lval[0]; qy_next = lval[1]; qz_next = lval[2];
      end
      rmq_pkg::BR_PIV_Y: begin
        qy_next = hval; qw_next = lval[0]; qz_next = lval[1]; qx_next = lval[2];
      end
      rmq_pkg::BR_PIV_Z: begin
        qz_next = hval; qw_next = lval[0]; qx_next = lval[1]; qy_next = lval[2];
      end
      default: begin
        qx_next = '0; qy_next = '0; qz_next = '0; qw_next = '0;
      end
    endcase
    if (dl.zero) begin
      qx_next = '0; qy_next = '0; qz_next = '0; qw_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[rmq_pkg::DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_x       <= qx_next;
      quat_y       <= qy_next;
      quat_z       <= qz_next;
      quat_w       <= qw_next;
      branch_taken <= dl.branch;
      degenerate   <= dl.zero;
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> quat_x == 0 && quat_y == 0 && quat_z == 0 && quat_w == 0)
    else $error("degenerate item with nonzero components");

  a_trace_w_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate && branch_taken == rmq_pkg::BR_TRACE |-> quat_w > 0)
    else $error("positive trace item with nonpositive w");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quat_x <= 18'sd65536 && quat_x >= -18'sd65536
               && quat_w <= 18'sd65536 && quat_w >= -18'sd65536)
    else $error("component outside unit range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quat_x) && $stable(branch_taken))
    else $error("stalled result changed");

endmodule

// ===== design/rmq_sqrt_cell.sv =====
module rmq_sqrt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            valid_in,
  input  rmq_pkg::sqrt_t  data_in,
  output logic            valid_out,
  output rmq_pkg::sqrt_t  data_out
);

  logic [rmq_pkg::REM_W+1:0] rem2;
  logic [rmq_pkg::REM_W+1:0] trial;
  logic                      ge;
  rmq_pkg::sqrt_t            data_next;

  always_comb begin
    rem2  = {data_in.rem, data_in.rad[rmq_pkg::RAD_W-1 -: 2]};
    trial = {2'b00, data_in.root, 2'b01};
    ge    = rem2 >= trial;
    data_next        = data_in;
    data_next.rad    = {data_in.rad[rmq_pkg::RAD_W-3:0], 2'b00};
    data_next.rem    = ge ? rmq_pkg::REM_W'(rem2 - trial) : rmq_pkg::REM_W'(rem2);
    data_next.root   = {data_in.root[rmq_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_out <= data_next;
    end
  end

endmodule

// ===== design/rmq_div_cell.sv =====
module rmq_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           valid_in,
  input  rmq_pkg::div_t  data_in,
  output logic           valid_out,
  output rmq_pkg::div_t  data_out
);

  logic [rmq_pkg::DEN_W:0] rem2 [rmq_pkg::LANES];
  logic                    ge   [rmq_pkg::LANES];
  rmq_pkg::div_t           data_next;

  always_comb begin
    data_next = data_in;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      rem2[l] = {data_in.rem[l], data_in.low[l][rmq_pkg::QB_W-1]};
      ge[l]   = rem2[l] >= {1'b0, data_in.den};
      data_next.rem[l] = ge[l] ? rmq_pkg::DEN_W'(rem2[l] - {1'b0, data_in.den})
                               : rmq_pkg::DEN_W'(rem2[l]);
      data_next.low[l] = {data_in.low[l][rmq_pkg::QB_W-2:0], 1'b0};
      data_next.quo[l] = {data_in.quo[l][rmq_pkg::QB_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_out <= data_next;
    end
  end

endmodule

// ===== dv/tb_rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic signed [17:0] qx, qy, qz, qw;
    rmq_pkg::branch_t br;
    logic degen;
  } quat_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [17:0] m00 = 0, m01 = 0, m02 = 0, m10 = 0, m11 = 0, m12 = 0;
  logic signed [17:0] m20 = 0, m21 = 0, m22 = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [17:0] quat_x, quat_y, quat_z, quat_w;
  logic [1:0] branch_taken;
  logic degenerate;

  quat_t expected_quats[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  rotation_matrix_to_quaternion dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  function automatic longint isqrt(longint v);
    longint r = 0;
    while ((r + 1) * (r + 1) <= v) begin
      longint s = 1;
      while ((r + 2 * s) * (r + 2 * s) <= v) s = s * 2;
      r = r + s;
    end
    return r;
  endfunction

  function automatic longint div_by_root(longint n, longint r);
    longint mag = n < 0 ? -n : n;
    longint q = ((mag <<< rmq_pkg::FRAC_BITS) + r) / (2 * r);
    return n < 0 ? -q : q;
  endfunction

  function automatic logic signed [17:0] clamp_unit(longint v);
    longint lim = 1 <<< rmq_pkg::FRAC_BITS;
    if (lim > 131071) lim = 131071;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[17:0];
  endfunction

  function automatic quat_t convert_matrix(logic signed [17:0] e[9]);
    longint m[3][3];
    longint q[4];
    longint one = 1 <<< rmq_pkg::FRAC_BITS;
    longint arg, r, tr, half;
    int i, j, k;
    quat_t res;
    for (int a = 0; a < 9; a++) m[a / 3][a % 3] = e[a];
    q = '{0, 0, 0, 0};
    i = 0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      res.br = rmq_pkg::BR_TRACE;
      arg = tr + one;
    end else begin
      if (m[0][0] < m[1][1]) i = (m[1][1] < m[2][2]) ? 2 : 1;
      else i = (m[0][0] < m[2][2]) ? 2 : 0;
      res.br = rmq_pkg::branch_t'(i + 1);
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      arg = m[i][i] - m[j][j] - m[k][k] + one;
    end
    if (arg < 0) arg = 0;
    r = isqrt(arg <<< rmq_pkg::FRAC_BITS);
    if (r != 0) begin
      half = (r + 1) >>> 1;
      if (res.br == rmq_pkg::BR_TRACE) begin
        q[3] = half;
        q[0] = div_by_root(m[2][1] - m[1][2], r);
        q[1] = div_by_root(m[0][2] - m[2][0], r);
        q[2] = div_by_root(m[1][0] - m[0][1], r);
      end else begin
        j = (i + 1) % 3;
        k = (i + 2) % 3;
        q[i] = half;
        q[3] = div_by_root(m[k][j] - m[j][k], r);
        q[j] = div_by_root(m[j][i] + m[i][j], r);
        q[k] = div_by_root(m[k][i] + m[i][k], r);
      end
    end
    res.qx = clamp_unit(q[0]);
    res.qy = clamp_unit(q[1]);
    res.qz = clamp_unit(q[2]);
    res.qw = clamp_unit(q[3]);
    res.degen = (r == 0);
    return res;
  endfunction

  task automatic send_matrix(logic signed [17:0] e[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
      {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_quats.insert(expected_quats.size(), convert_matrix(e));
  endtask

  function automatic logic signed [17:0] rand_elem();
    int sel = $urandom_range(9);
    if (sel == 0) return 18'($urandom);
    if (sel == 1) return 18'sd65536;
    if (sel == 2) return -18'sd65536;
    return 18'($signed($urandom_range(131072)) - 65536);
  endfunction

  task automatic send_diag(int d0, int d1, int d2);
    logic signed [17:0] e[9];
    foreach (e[n]) e[n] = 18'($signed($urandom_range(8192)) - 4096);
    e[0] = 18'(d0);
    e[4] = 18'(d1);
    e[8] = 18'(d2);
    send_matrix(e);
  endtask

  task automatic test_directed();
    logic signed [17:0] e[9];
    e = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};
    send_matrix(e);
    e = '{65536, 0, 0, 0, -65536, 0, 0, 0, -65536};
    send_matrix(e);
    e = '{-65536, 0, 0, 0, 65536, 0, 0, 0, -65536};
    send_matrix(e);
    e = '{-65536, 0, 0, 0, -65536, 0, 0, 0, 65536};
    send_matrix(e);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(e);
    e = '{-65536, 0, 0, 0, -65536, 0, 0, 0, -65536};
    send_matrix(e);
    e = '{-131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071, -131072};
    send_matrix(e);
    e = '{131071, 131071, 131071, -131072, 131071, -131072, 131071, 131071, 131071};
    send_matrix(e);
    e = '{0, -65536, 0, 65536, 0, 0, 0, 0, 1};
    send_matrix(e);
    e = '{0, 65536, 0, 65536, 0, 0, 0, 0, -65536};
    send_matrix(e);
    e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
    send_matrix(e);
    e = '{1, 0, 0, 0, 0, 0, 0, 0, -1};
    send_matrix(e);
    e = '{-1, 5, 7, 9, -1, 3, 2, 4, -1};
    send_matrix(e);
    e = '{0, 65536, 65536, 65536, 0, 65536, 65536, 65536, 0};
    send_matrix(e);
  endtask

  task automatic test_random(int count);
    logic signed [17:0] e[9];
    int a;
    repeat (count) begin
      case ($urandom_range(3))
        0: begin
          foreach (e[n]) e[n] = rand_elem();
          send_matrix(e);
        end
        1: begin
          a = $urandom_range(65536);
          send_diag(a, $urandom_range(65536) - 32768, $urandom_range(65536) - 32768);
        end
        2: begin
          a = -$signed($urandom_range(65536));
          case ($urandom_range(2))
            0: send_diag(-a / 2, a, a);
            1: send_diag(a, -a / 2, a);
            default: send_diag(a, a, -a / 2);
          endcase
        end
        default: begin
          a = $urandom_range(65536);
          send_diag(a, a, -2 * a);
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (expected_quats.size() != 0) @(posedge clk);
  endtask

  task automatic test_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    test_random(count);
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst && out_valid && out_ready) begin
      if (expected_quats.size() == 0) begin
        $error("unexpected item");
        errors++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (quat_x !== exp_q.qx) begin
          $error("quat_x exp %0d got %0d", exp_q.qx, quat_x);
          errors++;
        end
        if (quat_y !== exp_q.qy) begin
          $error("quat_y exp %0d got %0d", exp_q.qy, quat_y);
          errors++;
        end
        if (quat_z !== exp_q.qz) begin
          $error("quat_z exp %0d got %0d", exp_q.qz, quat_z);
          errors++;
        end
        if (quat_w !== exp_q.qw) begin
          $error("quat_w exp %0d got %0d", exp_q.qw, quat_w);
          errors++;
        end
        if (branch_taken !== exp_q.br) begin
          $error("branch_taken exp %0d got %0d", exp_q.br, branch_taken);
          errors++;
        end
        if (degenerate !== exp_q.degen) begin
          $error("degenerate exp %0d got %0d", exp_q.degen, degenerate);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_rotation_matrix_to_quaternion NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_phase(0, 0, 360);
    test_phase(74, 0, 360);
    test_phase(0, 74, 360);
    test_phase(35, 35, 360);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("tb_rotation_matrix_to_quaternion OK");
    end else begin
      $display("tb_rotation_matrix_to_quaternion NOT OK");
    end
    $finish;
  end

endmodule
